FILE: rtl/channel_intensity_mapper_defines.svh
// Assertion macros used by the checker file of the intensity mapper.
// No dependencies; include by bare file name inside a module body.
`ifndef CHANNEL_INTENSITY_MAPPER_DEFINES_SVH
`define CHANNEL_INTENSITY_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/chim_pkg.sv
// Shared types, widths and constant tables of the channel intensity mapper.
// No dependencies.
package chim_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned PCT_W          = 7;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned LOG_STEPS      = 100;
  localparam int unsigned S_W            = 34;   // holds values below 10^10
  localparam int unsigned DEC_W          = 4;
  localparam int unsigned HUND_W         = 7;
  localparam int unsigned LOGH_W         = 10;
  localparam int unsigned PROD_W         = 39;   // height * 100
  localparam int unsigned Q_STEPS        = 7;    // quotient bits below 128
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned BN_W           = 3400; // holds 10^999 and s^100
  localparam int unsigned PCT_FULL       = 100;
  localparam int unsigned LOG_ONE        = LOG_STEPS / 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR      = 3'd0,
    REG_CUT        = 3'd1,
    REG_CEIL_EN    = 3'd2,
    REG_LOG        = 3'd3,
    REG_PCT_DIV    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [DATA_W-1:0] floor_level;
    logic [DATA_W-1:0] cut_level;
    logic              ceiling_enable;
    logic              log_mode;
    logic [DATA_W-1:0] pct_div;     // zero already mapped to one
  } cfg_t;

  typedef logic [S_W-1:0] pow_tab_t [11];
  typedef logic [S_W-1:0] thr_tab_t [LOG_STEPS];

  function automatic pow_tab_t build_pow10();
    pow_tab_t t;
    int       k;
    t[0] = S_W'(1);
    for (k = 1; k < 11; k++) begin
      t[k] = t[k-1] * S_W'(10);
    end
    return t;
  endfunction

  localparam pow_tab_t POW10 = build_pow10();

  function automatic logic [BN_W-1:0] pow100(logic [S_W-1:0] s);
    logic [BN_W-1:0] b;
    logic [BN_W-1:0] p4;
    logic [BN_W-1:0] p32;
    b   = BN_W'(s);
    b   = b * b;
    b   = b * b;
    p4  = b;
    b   = b * b;
    b   = b * b;
    b   = b * b;
    p32 = b;
    b   = b * b;
    b   = b * p32;
    return b * p4;
  endfunction

  // Entry h is the smallest s with s^100 >= 10^(900+h).
  function automatic thr_tab_t build_thr();
    thr_tab_t        t;
    logic [BN_W-1:0] target;
    logic [S_W-1:0]  lo;
    logic [S_W-1:0]  hi;
    logic [S_W-1:0]  mid;
    int              i;
    int              h;
    target = BN_W'(1);
    for (i = 0; i < 900; i++) begin
      target = target * BN_W'(10);
    end
    lo = POW10[9] - S_W'(1);
    for (h = 0; h < LOG_STEPS; h++) begin
      hi = POW10[10];
      while (hi - lo > S_W'(1)) begin
        mid = lo + ((hi - lo) >> 1);
        if (pow100(mid) >= target) begin
          hi = mid;
        end else begin
          lo = mid;
        end
      end
      t[h]   = hi;
      lo     = hi - S_W'(1);
      target = target * BN_W'(10);
    end
    return t;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr();

endpackage

FILE: rtl/chim_cut.sv
// Floor and ceiling cut stage of the intensity mapper.
// Depends on chim_pkg.
module chim_cut #(
  parameter int unsigned COUNT_BITS = chim_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [chim_pkg::DATA_W-1:0] count_i,
  input  chim_pkg::cfg_t              cfg_i,
  output logic                        valid_o,
  output logic [chim_pkg::DATA_W-1:0] height_o
);
  import chim_pkg::*;

  localparam logic [DATA_W-1:0] CMASK =
    DATA_W'((64'(1) << COUNT_BITS) - 64'(1));

  logic [DATA_W-1:0] v, fl, cut, ceil_rel, diff, ht_d, ht_q;
  logic              valid_q;

  always_comb begin
    v        = count_i & CMASK;
    fl       = cfg_i.floor_level & CMASK;
    cut      = cfg_i.cut_level & CMASK;
    ceil_rel = (cut >= fl) ? cut - fl : '0;
    diff     = v - fl;
    if (v < fl) begin
      ht_d = '0;
    end else if (diff > ceil_rel) begin
      ht_d = cfg_i.ceiling_enable ? '0 : ceil_rel;
    end else begin
      ht_d = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ht_q <= ht_d;
    end
  end

  assign valid_o  = valid_q;
  assign height_o = ht_q;
endmodule

FILE: rtl/chim_log.sv
// Hundredths-of-decade log pipeline or bypass: decade, scale, compare, sum.
// Depends on chim_pkg (power and threshold tables).
module chim_log (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        log_en_i,
  input  logic                        valid_i,
  input  logic [chim_pkg::DATA_W-1:0] height_i,
  output logic                        valid_o,
  output logic [chim_pkg::DATA_W-1:0] height_o
);
  import chim_pkg::*;

  logic [3:0]              valid_q;
  logic [DATA_W-1:0]       v2_q, v3_q, v4_q, h5_q;
  logic [DEC_W-1:0]        d2_d, d2_q, d3_q, d4_q;
  logic [S_W-1:0]          s3_d, s3_q;
  logic [LOG_STEPS-1:1]    ge4_d, ge4_q;
  logic [HUND_W-1:0]       hund;
  logic [DATA_W-1:0]       h5_d;

  // Decade: count of the powers of ten from 10 to 10^9 not above the value.
  always_comb begin
    d2_d = '0;
    for (int k = 1; k < 10; k++) begin
      if (S_W'(height_i) >= POW10[k]) d2_d = d2_d + DEC_W'(1);
    end
  end

  // Scale into the range [10^9, 10^10).
  assign s3_d = S_W'((S_W + DATA_W)'(v2_q) * (S_W + DATA_W)'(POW10[DEC_W'(9) - d2_q]));

  always_comb begin
    for (int h = 1; h < LOG_STEPS; h++) begin
      ge4_d[h] = (s3_q >= THR_TAB[h]);
    end
  end

  always_comb begin
    hund = HUND_W'($countones(ge4_q));
    if (!log_en_i) begin
      h5_d = v4_q;
    end else if (v4_q == '0) begin
      h5_d = '0;
    end else if (v4_q == DATA_W'(1)) begin
      h5_d = DATA_W'(LOG_ONE);
    end else begin
      h5_d = DATA_W'(LOGH_W'(d4_q) * LOGH_W'(LOG_STEPS) + LOGH_W'(hund));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v2_q  <= height_i;
      d2_q  <= d2_d;
      v3_q  <= v2_q;
      d3_q  <= d2_q;
      s3_q  <= s3_d;
      v4_q  <= v3_q;
      d4_q  <= d3_q;
      ge4_q <= ge4_d;
      h5_q  <= h5_d;
    end
  end

  assign valid_o  = valid_q[3];
  assign height_o = h5_q;
endmodule

FILE: rtl/chim_pct.sv
// Percent-of-full-scale stage: product, saturation test, restoring division.
// Depends on chim_pkg.
module chim_pct (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [chim_pkg::DATA_W-1:0] pct_div_i,
  input  logic                        valid_i,
  input  logic [chim_pkg::DATA_W-1:0] height_i,
  output logic                        valid_o,
  output logic [chim_pkg::DATA_W-1:0] height_o,
  output logic [chim_pkg::PCT_W-1:0]  pct_o
);
  import chim_pkg::*;

  localparam int unsigned NST = Q_STEPS + 2;

  logic [NST-1:0]    valid_q;
  logic [PROD_W-1:0] pa_q, pb_q;
  logic [DATA_W-1:0] ha_q, hb_q;
  logic              sat_q;
  logic [PROD_W-1:0] fs_w;

  logic [PROD_W-1:0] rem_q [Q_STEPS];
  logic [PCT_W-1:0]  q_q   [Q_STEPS];
  logic [DATA_W-1:0] ht_q  [Q_STEPS];
  logic              st_q  [Q_STEPS];

  assign fs_w = PROD_W'(pct_div_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= PROD_W'(height_i) * PROD_W'(PCT_FULL);
      ha_q  <= height_i;
      pb_q  <= pa_q;
      hb_q  <= ha_q;
      sat_q <= (pa_q >= fs_w * PROD_W'(PCT_FULL));
    end
  end

  for (genvar j = 0; j < Q_STEPS; j++) begin : g_step
    localparam int unsigned SH = Q_STEPS - 1 - j;
    logic [PROD_W-1:0] rem_in, dvs, rem_d;
    logic [PCT_W-1:0]  q_in, q_d;
    logic [DATA_W-1:0] ht_in;
    logic              st_in;

    if (j == 0) begin : g_first
      assign rem_in = pb_q;
      assign q_in   = '0;
      assign ht_in  = hb_q;
      assign st_in  = sat_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign q_in   = q_q[j-1];
      assign ht_in  = ht_q[j-1];
      assign st_in  = st_q[j-1];
    end

    always_comb begin
      dvs   = fs_w << SH;
      rem_d = rem_in;
      q_d   = q_in;
      if (rem_in >= dvs) begin
        rem_d = rem_in - dvs;
        q_d   = q_in | PCT_W'(1 << SH);
      end
      // Final step: saturate and raise a nonzero height to at least one.
      if (j == Q_STEPS - 1) begin
        if (st_in) begin
          q_d = PCT_W'(PCT_FULL);
        end else if (q_d == '0 && ht_in != '0) begin
          q_d = PCT_W'(1);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        q_q[j]   <= q_d;
        ht_q[j]  <= ht_in;
        st_q[j]  <= st_in;
      end
    end
  end

  assign valid_o  = valid_q[NST-1];
  assign height_o = ht_q[Q_STEPS-1];
  assign pct_o    = q_q[Q_STEPS-1];
endmodule

FILE: rtl/channel_intensity_mapper.sv
// Top level of the channel intensity mapper: config registers, pipeline glue.
// Depends on chim_pkg, chim_cut, chim_log and chim_pct.
//
// Maps one histogram channel count per request to a plot height and a
// percent-of-full-scale intensity. The pipeline accepts one request every
// cycle while the master side does not stall, through 14 register stages of
// which the first loads at the accepting edge: one cut stage (floor subtract
// and ceiling test), four log stages (decade search, scale multiply, threshold
// compare, hundredths sum), two percent stages (the times-100 product and the
// saturation test) and seven restoring division stages, one quotient bit
// each. The whole pipeline advances as one when the output register is empty
// or taken, so a stall on the master side holds every stage. Write
// configuration only while no requests are in flight.
module channel_intensity_mapper #(
  parameter int unsigned COUNT_BITS = chim_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Config write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [chim_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [chim_pkg::DATA_W-1:0]    cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // [31:0] channel_count
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata   // [31:0] plot_height,
                                                        // [38:32] intensity_percent
);
  import chim_pkg::*;

  logic [DATA_W-1:0] floor_q, cut_q, fs_q;
  logic              ceil_en_q, log_q;
  cfg_t              cfg;
  logic              en;
  logic              cut_valid, log_valid, out_valid;
  logic [DATA_W-1:0] cut_ht, log_ht, out_ht;
  logic [PCT_W-1:0]  out_pct;

  // Config port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= '0;
      cut_q     <= '1;
      ceil_en_q <= 1'b0;
      log_q     <= 1'b0;
      fs_q      <= DATA_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FLOOR:      floor_q   <= cfg_data_i;
        REG_CUT:        cut_q     <= cfg_data_i;
        REG_CEIL_EN:    ceil_en_q <= cfg_data_i[0];
        REG_LOG:        log_q     <= cfg_data_i[0];
        REG_PCT_DIV:    fs_q      <= cfg_data_i;
        default:        ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    cfg.floor_level    = floor_q;
    cfg.cut_level      = cut_q;
    cfg.ceiling_enable = ceil_en_q;
    cfg.log_mode       = log_q;
    // A zero full scale divides as one.
    cfg.pct_div        = (fs_q == '0) ? DATA_W'(1) : fs_q;
  end

  // Advance every stage when the output register is free or being taken.
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  chim_cut #(.COUNT_BITS(COUNT_BITS)) u_cut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .count_i  (s_axis_tdata),
    .cfg_i    (cfg),
    .valid_o  (cut_valid),
    .height_o (cut_ht)
  );

  chim_log u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .log_en_i (cfg.log_mode),
    .valid_i  (cut_valid),
    .height_i (cut_ht),
    .valid_o  (log_valid),
    .height_o (log_ht)
  );

  chim_pct u_pct (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .pct_div_i (cfg.pct_div),
    .valid_i   (log_valid),
    .height_i  (log_ht),
    .valid_o   (out_valid),
    .height_o  (out_ht),
    .pct_o     (out_pct)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_pct, out_ht};
endmodule

FILE: rtl/chim_checker.sv
// Port-level checks of the channel intensity mapper, bound to the top level.
// Depends on channel_intensity_mapper_defines.svh.
module chim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  `include "channel_intensity_mapper_defines.svh"

  `CIM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `CIM_ASSERT_NOW(a_pct_range, m_axis_tvalid, m_axis_tdata[38:32] <= 7'd100, "intensity above 100")
  `CIM_ASSERT_NOW(a_pct_zero, m_axis_tvalid, (m_axis_tdata[31:0] == 32'd0) == (m_axis_tdata[38:32] == 7'd0), "intensity zero mismatch")
  `CIM_ASSERT_NOW(a_ready_free, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
endmodule

bind channel_intensity_mapper chim_checker u_chim_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb_channel_intensity_mapper.sv
// Self-checking bench for channel_intensity_mapper: stream stimulus, config phases,
// own height/percent predictor with a decade threshold table. Depends on chim_pkg.
`timescale 1ns / 1ps

module tb_channel_intensity_mapper;
  import chim_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [6:0]  pct;
    logic [31:0] height;
  } plot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  channel_intensity_mapper dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor copy of the register file.
  logic [31:0] floor_r = 0, cut_r = 32'hFFFF_FFFF, fs_r = 1;
  logic        ceil_en_r = 0, log_r = 0;
  logic [63:0] decade_thr [100];

  logic [31:0] pending_counts [$];
  plot_t       expected_plots [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 0, recv_stall = 0;  // percent

  // Handshake flag latched at the rising edge so the driver sees an exact accept.
  logic s_axis_tready_q = 1'b0;

  function automatic logic [63:0] pow_ten(int k);
    logic [63:0] p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // s^100 by squaring: 2, 4, 8, 16, 32, 64, 96, 100.
  function automatic logic [3399:0] pow_hundred(logic [63:0] s);
    logic [3399:0] b, p4, p32;
    b   = 3400'(s);
    b   = b * b;
    b   = b * b;
    p4  = b;
    b   = b * b;
    b   = b * b;
    b   = b * b;
    p32 = b;
    b   = b * b;
    b   = b * p32;
    return b * p4;
  endfunction

  // Smallest s with s^100 >= 10^(900+h); exact via big integer compare.
  task automatic build_decade_thr();
    logic [3399:0] goal;
    logic [63:0] lo, hi, mid;
    goal = 1;
    for (int i = 0; i < 900; i++) goal = goal * 10;
    lo = pow_ten(9) - 1;
    for (int h = 0; h < 100; h++) begin
      hi = pow_ten(10);
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (pow_hundred(mid) >= goal) hi = mid; else lo = mid;
      end
      decade_thr[h] = hi;
      lo = hi - 1;
      goal = goal * 10;
    end
  endtask

  function automatic logic [31:0] hundredths_of_decade(logic [31:0] v);
    int d, h;
    logic [63:0] s;
    if (v == 0) return 0;
    if (v == 1) return LOG_ONE;
    d = 0;
    while (d < 9 && 64'(v) >= pow_ten(d + 1)) d++;
    s = 64'(v) * pow_ten(9 - d);
    h = 0;
    while (h + 1 < 100 && s >= decade_thr[h + 1]) h++;
    return 32'(100 * d + h);
  endfunction

  function automatic plot_t map_channel(logic [31:0] v);
    plot_t r;
    logic [31:0] rel, ht;
    logic [63:0] fs, pct;
    rel = (cut_r >= floor_r) ? cut_r - floor_r : 0;
    if (v < floor_r) ht = 0;
    else begin
      ht = v - floor_r;
      if (ht > rel) ht = ceil_en_r ? 32'd0 : rel;
    end
    if (log_r) ht = hundredths_of_decade(ht);
    fs = (fs_r == 0) ? 64'd1 : 64'(fs_r);
    pct = (64'(ht) * 100) / fs;
    if (pct == 0 && ht != 0) pct = 1;
    if (pct > 100) pct = 100;
    r.height = ht;
    r.pct = pct[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // Driver: present the next pending request at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_counts.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_counts.pop_front();
        end else s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk_i) begin
    plot_t got, want;
    cycles <= cycles + 1;
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) expected_plots.push_back(map_channel(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[38:0];
      if (expected_plots.size() == 0) begin
        report_mismatch("unexpected result", got.height, 32'd0);
      end else begin
        want = expected_plots.pop_front();
        if (got.height !== want.height) report_mismatch("plot_height", got.height, want.height);
        if (got.pct !== want.pct) report_mismatch("intensity_percent", 32'(got.pct), 32'(want.pct));
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_channel_intensity_mapper failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_FLOOR:      floor_r = val;
      REG_CUT:        cut_r = val;
      REG_CEIL_EN:    ceil_en_r = val[0];
      REG_LOG:        log_r = val[0];
      REG_PCT_DIV:    fs_r = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every request has come back, then let the pipe settle.
  task automatic drain();
    while (pending_counts.size() > 0 || s_axis_tvalid || expected_plots.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(5))
      0: return $urandom_range(20);
      1: return 32'hFFFF_FFFF - $urandom_range(20);
      2: return floor_r + $urandom_range(3) - 1;
      3: return cut_r + $urandom_range(3) - 1;
      4: return 32'(pow_ten($urandom_range(9)) + $urandom_range(2) - 1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int setting;
    build_decade_thr();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes at the reset setting, powers of ten in log mode, then a floor above the cut.
    foreach (pending_counts[i]) ;
    pending_counts = '{0, 1, 2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    drain();
    write_reg(REG_LOG, 1);
    write_reg(REG_PCT_DIV, 0);         // zero full scale acts as one
    pending_counts = '{0, 1, 9, 10, 99, 100, 999999999, 1000000000, 32'hFFFF_FFFF,
                       31622, 31623, 3162277660};
    drain();
    write_reg(REG_FLOOR, 100);
    write_reg(REG_CUT, 50);            // relative ceiling below zero clamps to zero
    write_reg(REG_CEIL_EN, 1);
    write_reg(REG_LOG, 0);
    write_reg(REG_PCT_DIV, 32'hFFFF_FFFF);
    pending_counts = '{99, 100, 101, 32'hFFFF_FFFF, 0};
    drain();

    // Random phases over settings and idling patterns.
    for (setting = 0; setting < 16; setting++) begin
      case (setting % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 76; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 76; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      write_reg(REG_FLOOR, ($urandom_range(2) == 0) ? 0 : $urandom >> $urandom_range(31));
      write_reg(REG_CUT, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom >> $urandom_range(31));
      write_reg(REG_CEIL_EN, $urandom_range(1));
      write_reg(REG_LOG, $urandom_range(1));
      write_reg(REG_PCT_DIV, ($urandom_range(4) == 0) ? $urandom_range(1)
                             : $urandom >> $urandom_range(31));
      repeat (25) pending_counts.push_back(rand_count());
      drain();
    end

    if (errors == 0) $display("tb_channel_intensity_mapper passed");
    else $display("tb_channel_intensity_mapper failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/chim_pkg.sv
rtl/chim_cut.sv
rtl/chim_log.sv
rtl/chim_pct.sv
rtl/channel_intensity_mapper.sv
rtl/chim_checker.sv
bench/tb_channel_intensity_mapper.sv
